@@ src/tlg_pkg.sv @@
package tlg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_END,
    ST_RD_MID,
    ST_RD_DOWN,
    ST_FIN
  } tlg_state_e;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  localparam logic [15:0] HALF_FRAC    = 16'h8000;
  localparam logic [6:0]  SIZE_RESET   = 7'd64;
  localparam int unsigned MIN_SIZE     = 3;

endpackage

@@ src/toroidal_life_generation_with_noise.sv @@
// Toroidal Game of Life with noise, one cell per input beat. Mode 0 beats load the current
// bank in raster order with no output beat, and can follow one another back to back while
// no size change is being mapped. A mode 1 beat evolves the cell at the raster position into
// the other bank and yields one output beat; it holds the block through ST_RD_MID, ST_RD_DOWN
// and ST_FIN, since the single read port of the row memory fetches the rows above, at and
// below the cell one after another. An evolve beat also waits in ST_FIN while an earlier
// output beat is still held. The banks swap after the last cell of a generation, flagged by
// tlast. After a write to either size register the raster position is mapped onto the new
// grid by a shift-subtract divider before the next beat is accepted. The sizes in use are the
// size registers clamped to 3 .. MAX_COLUMNS and 3 .. MAX_ROWS. Cells never written read as undefined.
module toroidal_life_generation_with_noise
  import tlg_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // load_value [0], gate_draw [16:1], state_draw [32:17], zero fill above.
  input  logic [39:0] s_axis_tdata,
  // mode [0].
  input  logic        s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_cell [0], cell_row [6:1], cell_column [12:7], zero fill above.
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int PW  = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int BW  = $clog2(PW);
  localparam int AW  = $clog2(2 * MAX_ROWS);

  tlg_state_e state_q, state_d;

  logic [15:0]    thr_q;
  logic [6:0]     cols_cfg_q, rows_cfg_q;
  logic           resync_q, resync_d;
  logic           bank_q, bank_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic           wrap_q, wrap_d;

  logic [CNW-1:0] rem_q, rem_d;
  logic [PW-1:0]  quot_q, quot_d;
  logic [BW-1:0]  bit_idx_q, bit_idx_d;

  logic           rule_q, rule_d;
  logic           noise_q, noise_d;
  logic [2:0]     up_q, up_d;
  logic [2:0]     mid_q, mid_d;

  logic           out_valid_q, out_valid_d;
  logic           out_cell_q, out_cell_d;
  logic [RW-1:0]  out_row_q, out_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic           out_last_q, out_last_d;

  logic [MAX_COLUMNS-1:0] grid_q [2*MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rdata_q;

  logic [CNW-1:0] cols_c;
  logic [RNW-1:0] rows_c;
  logic [CW-1:0]  col_left, col_right;
  logic [RW-1:0]  row_up, row_down;
  logic           col_end, row_end, last;
  logic           accept, fin_go, load_go;
  logic           rd_en, wr_en, wr_bit;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [RW-1:0]  rd_row;
  logic           wr_bank;
  logic [2:0]     down_bits;
  logic [3:0]     nb_count;
  logic           next_cell;
  logic [CNW:0]   trial;
  logic           trial_ge;

  function automatic logic [AW-1:0] row_addr(input logic bank, input logic [RW-1:0] row);
    row_addr = bank ? AW'(MAX_ROWS) + AW'(row) : AW'(row);
  endfunction

  always_comb begin
    if (cols_cfg_q < 7'(MIN_SIZE)) begin
      cols_c = CNW'(MIN_SIZE);
    end else if (32'(cols_cfg_q) > MAX_COLUMNS) begin
      cols_c = CNW'(MAX_COLUMNS);
    end else begin
      cols_c = CNW'(cols_cfg_q);
    end
    if (rows_cfg_q < 7'(MIN_SIZE)) begin
      rows_c = RNW'(MIN_SIZE);
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      rows_c = RNW'(MAX_ROWS);
    end else begin
      rows_c = RNW'(rows_cfg_q);
    end
  end

  assign col_end   = (32'(col_q) + 32'd1) == 32'(cols_c);
  assign row_end   = (32'(row_q) + 32'd1) == 32'(rows_c);
  assign last      = col_end && row_end;
  assign col_left  = (col_q == '0) ? CW'(cols_c - CNW'(1)) : CW'(col_q - 1'b1);
  assign col_right = col_end ? '0 : CW'(col_q + 1'b1);
  assign row_up    = (row_q == '0) ? RW'(rows_c - RNW'(1)) : RW'(row_q - 1'b1);
  assign row_down  = row_end ? '0 : RW'(row_q + 1'b1);

  assign trial    = {rem_q, pos_q[bit_idx_q]};
  assign trial_ge = trial >= (CNW + 1)'(cols_c);

  assign down_bits = {rdata_q[col_right], rdata_q[col_q], rdata_q[col_left]};
  assign nb_count  = 4'(up_q[0]) + 4'(up_q[1]) + 4'(up_q[2]) + 4'(mid_q[0]) + 4'(mid_q[2])
                   + 4'(down_bits[0]) + 4'(down_bits[1]) + 4'(down_bits[2]);

  always_comb begin
    if (rule_q) begin
      if (mid_q[1]) begin
        next_cell = (nb_count == 4'd2) || (nb_count == 4'd3);
      end else begin
        next_cell = (nb_count == 4'd3);
      end
    end else begin
      next_cell = noise_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (resync_q) begin
          state_d = ST_DIV;
        end else if (s_axis_tvalid && s_axis_tuser) begin
          state_d = ST_RD_MID;
        end
      end
      ST_DIV: begin
        if (bit_idx_q == '0) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: state_d = ST_IDLE;
      ST_RD_MID:  state_d = ST_RD_DOWN;
      ST_RD_DOWN: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_row        = row_q;
    fin_go        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = !resync_q;
        rd_en         = 1'b1;
        rd_row        = row_up;
      end
      ST_RD_MID: begin
        rd_en  = 1'b1;
        rd_row = row_q;
      end
      ST_RD_DOWN: begin
        rd_en  = 1'b1;
        rd_row = row_down;
      end
      ST_FIN: fin_go = !out_valid_q || m_axis_tready;
      default: begin
      end
    endcase
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load_go = accept && !s_axis_tuser;
  assign wr_en   = load_go || fin_go;
  assign wr_bank = load_go ? bank_q : !bank_q;
  assign wr_bit  = load_go ? s_axis_tdata[0] : next_cell;
  assign wr_addr = row_addr(wr_bank, row_q);
  assign rd_addr = row_addr(bank_q, rd_row);

  always_comb begin
    resync_d    = resync_q;
    bank_d      = bank_q;
    row_d       = row_q;
    col_d       = col_q;
    pos_d       = pos_q;
    wrap_d      = wrap_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    bit_idx_d   = bit_idx_q;
    rule_d      = rule_q;
    noise_d     = noise_q;
    up_d        = up_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_cell_d  = out_cell_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;

    if (state_q == ST_IDLE && resync_q) begin
      resync_d  = 1'b0;
      rem_d     = '0;
      quot_d    = '0;
      bit_idx_d = BW'(PW - 1);
    end
    if (state_q == ST_DIV) begin
      rem_d     = trial_ge ? CNW'(trial - (CNW + 1)'(cols_c)) : CNW'(trial);
      quot_d    = {quot_q[PW-2:0], trial_ge};
      bit_idx_d = bit_idx_q - 1'b1;
    end
    if (state_q == ST_DIV_END) begin
      if (32'(quot_q) < 32'(rows_c)) begin
        row_d  = RW'(quot_q);
        col_d  = CW'(rem_q);
        wrap_d = 1'b0;
      end else begin
        // The stored position is kept so that a later size change can still map it.
        row_d  = '0;
        col_d  = '0;
        wrap_d = 1'b1;
      end
    end
    if (accept) begin
      rule_d  = s_axis_tdata[16:1] > thr_q;
      noise_d = s_axis_tdata[32:17] < HALF_FRAC;
    end
    if (state_q == ST_RD_MID) begin
      up_d = {rdata_q[col_right], rdata_q[col_q], rdata_q[col_left]};
    end
    if (state_q == ST_RD_DOWN) begin
      mid_d = {rdata_q[col_right], rdata_q[col_q], rdata_q[col_left]};
    end
    if (fin_go) begin
      out_valid_d = 1'b1;
      out_cell_d  = next_cell;
      out_row_d   = row_q;
      out_col_d   = col_q;
      out_last_d  = last;
      if (last) begin
        bank_d = !bank_q;
      end
    end
    if (load_go || fin_go) begin
      wrap_d = 1'b0;
      if (last) begin
        row_d = '0;
        col_d = '0;
        pos_d = '0;
      end else begin
        pos_d = wrap_q ? PW'(1) : pos_q + 1'b1;
        if (col_end) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
    if (cfg_we_i && (cfg_index_i == CFG_COLUMNS || cfg_index_i == CFG_ROWS)) begin
      resync_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      cols_cfg_q  <= SIZE_RESET;
      rows_cfg_q  <= SIZE_RESET;
      resync_q    <= 1'b0;
      bank_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      wrap_q      <= 1'b0;
      bit_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      resync_q    <= resync_d;
      bank_q      <= bank_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pos_q       <= pos_d;
      wrap_q      <= wrap_d;
      bit_idx_q   <= bit_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_THRESHOLD: thr_q      <= cfg_data_i;
          CFG_COLUMNS:   cols_cfg_q <= cfg_data_i[6:0];
          CFG_ROWS:      rows_cfg_q <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    rule_q     <= rule_d;
    noise_q    <= noise_d;
    up_q       <= up_d;
    mid_q      <= mid_d;
    out_cell_q <= out_cell_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_q[wr_addr][col_q] <= wr_bit;
    end
    if (rd_en) begin
      rdata_q <= grid_q[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, 6'(out_col_q), 6'(out_row_q), out_cell_q};

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("output beat raised outside the final evolve cycle");

  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !resync_q) |->
      (32'(col_q) < 32'(cols_c) && 32'(row_q) < 32'(rows_c)))
    else $error("raster position outside the active grid");

  a_swap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && last) |=> (bank_q != $past(bank_q)))
    else $error("banks did not swap after the last cell of a generation");

  a_evolve_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |=> (state_q == ST_RD_MID))
    else $error("evolve beat did not start the row fetch");

endmodule
